@@ hdl/wisu_pkg.sv @@
// ----------------------------------------------------------------------------
// wisu_pkg
// Shared types, widths and codes of the weighted index sampler.
// ----------------------------------------------------------------------------
package wisu_pkg;

	// table geometry
	localparam int ENTRIES = 256;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int SUM_W   = 40;
	localparam int WGT_W   = 32;
	localparam int RAND_W  = 32;

	// select tree: leaves per first-level group
	localparam int GROUP  = 16;
	localparam int GROUPS = ENTRIES / GROUP;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// operation codes
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_SAMPLE = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [WGT_W-1:0]  weight;
		logic [RAND_W-1:0] random_fraction;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       index;
		logic [1:0]       status;
		logic [SUM_W-1:0] total;
	} res_t;

	// broadcast to every cell
	typedef struct packed {
		logic             load;
		logic             remove;
		logic [IDX_W-1:0] slot;
		logic [SUM_W-1:0] load_sum;
		logic [SUM_W-1:0] target;
		logic [SUM_W-1:0] rm_weight;
	} cell_ctrl_t;

	// what a cell offers to the select tree (zero unless it is the chosen one)
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [SUM_W-1:0] weight;
	} pick_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TGT,
		ST_CMP,
		ST_PICK,
		ST_SEL,
		ST_REMOVE,
		ST_DONE
	} state_t;

endpackage

@@ hdl/wisu_cell.sv @@
// ----------------------------------------------------------------------------
// wisu_cell
// One table slot: holds a running sum, compares it with the target and
// detects the first slot at or above the target from its left neighbor.
// ----------------------------------------------------------------------------
module wisu_cell
	import wisu_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] slot_index,
	input  logic [CNT_W-1:0] count,
	input  logic [SUM_W-1:0] left_sum,
	input  logic             left_ge,
	output logic [SUM_W-1:0] sum,
	output logic             ge,
	output pick_t            pick
);

	logic [SUM_W-1:0] sum_q;
	logic             ge_q;
	logic             live;
	logic             first;

	// slot holds a table entry
	assign live = {1'b0, slot_index} < count;

	// compare against the broadcast target
	always_ff @(posedge clk) begin
		ge_q <= sum_q >= ctrl.target;
	end

	// load on append; on removal, live cells at or above the target shift down by the removed weight
	always_ff @(posedge clk) begin
		if (ctrl.load && (slot_index == ctrl.slot)) begin
			sum_q <= ctrl.load_sum;
		end else if (ctrl.remove && live && ge_q) begin
			sum_q <= sum_q - ctrl.rm_weight;
		end
	end

	// sums are monotone, so the first slot at or above target sees its left below
	assign first = live && ge_q && !left_ge;

	always_comb begin
		pick.idx    = first ? slot_index : '0;
		pick.weight = first ? (sum_q - left_sum) : '0;
	end

	assign sum = sum_q;
	assign ge  = ge_q;

endmodule

@@ hdl/wisu_tree.sv @@
// ----------------------------------------------------------------------------
// wisu_tree
// Two-stage registered OR tree that collects the single chosen cell's
// index and weight from the row of cells.
// ----------------------------------------------------------------------------
module wisu_tree
	import wisu_pkg::*;
(
	input  logic  clk,
	input  pick_t picks [ENTRIES],
	output pick_t sel
);

	pick_t group_d  [GROUPS];
	pick_t group_s1 [GROUPS];
	pick_t sel_d;
	pick_t sel_s2;

	// first level: OR within each group of cells
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			group_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				group_d[g] = group_d[g] | picks[g * GROUP + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		group_s1 <= group_d;
	end

	// second level: OR across groups
	always_comb begin
		sel_d = '0;
		for (int g = 0; g < GROUPS; g++) begin
			sel_d = sel_d | group_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		sel_s2 <= sel_d;
	end

	assign sel = sel_s2;

endmodule

@@ hdl/weighted_index_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// weighted_index_sampler_unit
// Roulette-wheel sampler over a table of running weight sums.
// ----------------------------------------------------------------------------
// Items arrive on cmd (valid/stall) and each gives one item on res.
// Clear, append and the error cases (empty distribution, full table) go
// from the execute step straight to the output register load. A sample
// or sample-and-remove runs through the target multiply, the target add,
// the compare of every cell's running sum with the target, the registered
// select tree, the removal update and the load of the output register.
// The block works on one item at a time; cmd_stall is low again the
// cycle after the result moves to the output register.
// The output register holds a finished item while res_stall is high and the
// next item is accepted meanwhile; that item waits in its last step until
// the output register frees up.
// Reset empties the table (entry count and total go to zero) and clears
// res_valid; the running sums themselves are not cleared.
// ----------------------------------------------------------------------------
module weighted_index_sampler_unit
	import wisu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	state_t           state_q;
	state_t           state_d;
	cmd_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] total_q;
	logic [63:0]      prod_lo_s1;
	logic [SUM_W-1:0] prod_hi_s1;
	logic [SUM_W-1:0] t_q;
	res_t             result_q;
	res_t             res_q;
	logic             res_valid_q;

	logic             accept;
	logic             res_free;
	logic             full;
	logic             empty;
	logic             sampling;
	logic [SUM_W:0]   app_ext;
	logic [SUM_W-1:0] app_sum;
	logic [SUM_W:0]   tgt_ext;
	logic [SUM_W-1:0] rem_total;
	cell_ctrl_t       ctrl;
	pick_t            picks [ENTRIES];
	pick_t            sel;
	logic [SUM_W-1:0] sums  [ENTRIES];
	logic             ges   [ENTRIES];
	logic [IDX_W-1:0] last_idx;

	assign accept   = cmd_valid && (state_q == ST_IDLE);
	assign res_free = !res_valid_q || !res_stall;
	assign full     = count_q >= CNT_W'(ENTRIES);
	assign empty    = (total_q == '0) || (count_q == '0);
	assign sampling = (req_q.mode == MODE_SAMPLE) || (req_q.mode == MODE_REMOVE);

	// saturating append sum
	assign app_ext = {1'b0, total_q} + (SUM_W + 1)'(req_q.weight);
	assign app_sum = app_ext[SUM_W] ? SUM_MAX : app_ext[SUM_W-1:0];

	// target = floor(r * total / 2^32) + 1
	assign tgt_ext = (SUM_W + 1)'(prod_hi_s1) + (SUM_W + 1)'(prod_lo_s1[63:32])
		+ (SUM_W + 1)'(1);

	assign rem_total = total_q - sel.weight;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = (sampling && !empty) ? ST_TGT : ST_DONE;
			end
			ST_TGT:    state_d = ST_CMP;
			ST_CMP:    state_d = ST_PICK;
			ST_PICK:   state_d = ST_SEL;
			ST_SEL:    state_d = ST_REMOVE;
			ST_REMOVE: state_d = ST_DONE;
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// cell broadcast
	always_comb begin
		ctrl.load      = (state_q == ST_EXEC) && (req_q.mode == MODE_APPEND) && !full;
		ctrl.remove    = (state_q == ST_REMOVE) && (req_q.mode == MODE_REMOVE);
		ctrl.slot      = count_q[IDX_W-1:0];
		ctrl.load_sum  = app_sum;
		ctrl.target    = t_q;
		ctrl.rm_weight = sel.weight;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				if (req_q.mode == MODE_CLEAR) begin
					count_q <= '0;
					total_q <= '0;
				end else if ((req_q.mode == MODE_APPEND) && !full) begin
					count_q <= count_q + CNT_W'(1);
					total_q <= app_sum;
				end
			end
			if (ctrl.remove) begin
				total_q <= rem_total;
			end
			if ((state_q == ST_DONE) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// item capture, target arithmetic and result build
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= cmd;
		end
		prod_lo_s1 <= 64'(req_q.random_fraction) * 64'(total_q[31:0]);
		prod_hi_s1 <= SUM_W'(req_q.random_fraction) * SUM_W'(total_q[SUM_W-1:32]);
		t_q        <= tgt_ext[SUM_W-1:0];
		if (state_q == ST_EXEC) begin
			if (req_q.mode == MODE_CLEAR) begin
				result_q <= '{index: '0, status: STATUS_OK, total: '0};
			end else if (req_q.mode == MODE_APPEND) begin
				if (full) begin
					result_q <= '{index: '0, status: STATUS_FULL, total: total_q};
				end else begin
					result_q <= '{index: 8'(count_q[IDX_W-1:0]), status: STATUS_OK,
						total: app_sum};
				end
			end else begin
				result_q <= '{index: '0, status: STATUS_EMPTY, total: total_q};
			end
		end
		if (state_q == ST_REMOVE) begin
			result_q <= '{index: 8'(sel.idx), status: STATUS_OK,
				total: ctrl.remove ? rem_total : total_q};
		end
		if ((state_q == ST_DONE) && res_free) begin
			res_q <= result_q;
		end
	end

	// row of cells, each fed by its left neighbor
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		wisu_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.slot_index(IDX_W'(i)),
			.count     (count_q),
			.left_sum  ((i == 0) ? '0 : sums[(i == 0) ? 0 : i - 1]),
			.left_ge   ((i == 0) ? 1'b0 : ges[(i == 0) ? 0 : i - 1]),
			.sum       (sums[i]),
			.ge        (ges[i]),
			.pick      (picks[i])
		);
	end

	wisu_tree u_tree (
		.clk  (clk),
		.picks(picks),
		.sel  (sel)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// the table never holds more entries than it has cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	// while idle with a non-empty table, the kept total matches the last running sum
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && (count_q != '0)) |-> (total_q == sums[last_idx]))
		else $error("total and last running sum disagree");

	// a chosen entry always lies inside the table
	a_pick_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REMOVE) |-> ({1'b0, sel.idx} < count_q))
		else $error("chosen index outside table");

	// an accepted item always starts execution next
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == ST_EXEC))
		else $error("accepted item not executed");

endmodule

@@ tb/weighted_index_sampler_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_index_sampler_unit_test
// Self-checking bench for the roulette-wheel sampler. A short table of
// directed items covers the empty and zero-weight corners, the extreme
// weights and fractions, and clear. Random rounds follow: mostly a clear, a
// burst of appends (now and then past a full table), then a mix of samples
// and removals. Each accepted item runs through a behavioral model of the
// running-sum table; its result, or a directed row's fixed one, is queued in
// order for comparison with the output. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module weighted_index_sampler_unit_test
	import wisu_pkg::*;
();

	localparam int RANDOM_ITEMS = 1350;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	// model of the running-sum table
	logic [SUM_W-1:0] cum_sums [ENTRIES];
	int               n_entries;
	logic [SUM_W-1:0] sum_total;

	res_t     pick_queue [$];
	dir_row_t dir_rows [$];
	int       fails;
	int       items_sent;
	int       fills_done;
	bit       quiet_send;

	weighted_index_sampler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// apply one item to the model table and return the result it gives
	function automatic res_t predict_pick(input cmd_t c);
		res_t             o;
		logic [71:0]      prod;
		logic [SUM_W:0]   wide;
		logic [SUM_W-1:0] tgt;
		logic [SUM_W-1:0] prev;
		logic [SUM_W-1:0] taken;
		int               pick;
		o.index  = '0;
		o.status = STATUS_OK;
		case (c.mode)
			MODE_CLEAR: begin
				n_entries = 0;
				sum_total = '0;
			end
			MODE_APPEND: begin
				if (n_entries >= ENTRIES) begin
					o.status = STATUS_FULL;
				end else begin
					// running sum saturates at the top of its width
					wide = {1'b0, sum_total} + {{(SUM_W + 1 - WGT_W){1'b0}}, c.weight};
					sum_total = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
					cum_sums[n_entries] = sum_total;
					o.index = 8'(n_entries);
					n_entries++;
				end
			end
			default: begin
				if (sum_total == '0 || n_entries == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					// target in 1..total
					prod = {40'b0, c.random_fraction} * {32'b0, sum_total};
					tgt  = prod[71:32] + 1'b1;
					// first entry reaching the target, else the last one
					pick = n_entries - 1;
					for (int k = n_entries - 1; k >= 0; k--) begin
						if (cum_sums[k] >= tgt)
							pick = k;
					end
					o.index = 8'(pick);
					if (c.mode == MODE_REMOVE) begin
						prev  = (pick > 0) ? cum_sums[pick-1] : '0;
						taken = cum_sums[pick] - prev;
						for (int k = pick; k < n_entries; k++)
							cum_sums[k] = cum_sums[k] - taken;
						sum_total = cum_sums[n_entries-1];
					end
				end
			end
		endcase
		o.total = sum_total;
		return o;
	endfunction

	function automatic cmd_t make_cmd(input logic [1:0] m, input logic [WGT_W-1:0] w,
			input logic [RAND_W-1:0] r);
		cmd_t c;
		c.mode            = m;
		c.weight          = w;
		c.random_fraction = r;
		return c;
	endfunction

	function automatic res_t make_res(input logic [7:0] i, input logic [1:0] s,
			input logic [SUM_W-1:0] t);
		res_t o;
		o.index  = i;
		o.status = s;
		o.total  = t;
		return o;
	endfunction

	function automatic void add_row(input logic [1:0] m, input logic [WGT_W-1:0] w,
			input logic [RAND_W-1:0] r, input bit typed, input res_t want);
		dir_row_t row;
		row.c     = make_cmd(m, w, r);
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [WGT_W-1:0] pick_weight();
		logic [WGT_W-1:0] w;
		case ($urandom_range(0, 9))
			0:       w = '0;
			1, 2:    w = $urandom_range(1, 15);
			3, 4:    w = $urandom_range(1, 1000);
			8:       w = '1;
			9:       w = $urandom >> $urandom_range(0, 31);
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic [RAND_W-1:0] pick_fraction();
		logic [RAND_W-1:0] r;
		case ($urandom_range(0, 9))
			7:       r = '0;
			8:       r = '1;
			9:       r = $urandom_range(0, 255);
			default: r = $urandom;
		endcase
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (quiet_send || roll < 45)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		return gap;
	endfunction

	// offer one item, wait for accept, queue its expected result
	task automatic push_item(input cmd_t c, input bit typed, input res_t want);
		cmd_t junk;
		res_t model_res;
		int   gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			junk.mode            = 2'($urandom_range(0, 3));
			junk.weight          = $urandom;
			junk.random_fraction = $urandom;
			cmd_valid <= 1'b0;
			cmd       <= junk;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		model_res = predict_pick(c);
		pick_queue.push_back(typed ? want : model_res);
		items_sent++;
	endtask

	// usually a clear, then a burst of appends, then samples and removals
	task automatic run_draw_round();
		int n_add;
		int n_draw;
		quiet_send = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 4) != 0)
			push_item(make_cmd(MODE_CLEAR, $urandom, $urandom), 1'b0, '0);
		if (fills_done < 3 && $urandom_range(0, 19) == 0) begin
			n_add = ENTRIES + $urandom_range(1, 6);
			fills_done++;
		end else begin
			n_add = $urandom_range(1, 24);
		end
		repeat (n_add)
			push_item(make_cmd(MODE_APPEND, pick_weight(), $urandom), 1'b0, '0);
		n_draw = $urandom_range(1, 30);
		repeat (n_draw) begin
			if ($urandom_range(0, 9) < 4)
				push_item(make_cmd(MODE_REMOVE, $urandom, pick_fraction()), 1'b0, '0);
			else
				push_item(make_cmd(MODE_SAMPLE, $urandom, pick_fraction()), 1'b0, '0);
		end
		quiet_send = 1'b0;
	endtask

	// result side: random stall with quiet stretches
	initial begin
		int  stall_left;
		int  quiet_left;
		int  roll;
		logic next_stall;
		stall_left = 0;
		quiet_left = 0;
		res_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet_left > 0) begin
				quiet_left--;
				next_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					quiet_left = $urandom_range(20, 100);
					next_stall = 1'b0;
				end else if (roll < 70) begin
					next_stall = 1'b0;
				end else if (roll < 95) begin
					stall_left = $urandom_range(0, 2);
					next_stall = 1'b1;
				end else begin
					stall_left = $urandom_range(10, 40);
					next_stall = 1'b1;
				end
			end
			res_stall <= next_stall;
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pick_queue.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("%0t: result with none expected: index %0d status %0d total %h",
						$realtime, res.index, res.status, res.total);
			end else begin
				want = pick_queue.pop_front();
				if (res.index !== want.index || res.status !== want.status ||
						res.total !== want.total) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: mismatch: index %0d/%0d status %0d/%0d total %h/%h (exp/act)",
							$realtime, want.index, res.index, want.status, res.status,
							want.total, res.total);
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd        = '0;
		fails      = 0;
		items_sent = 0;
		fills_done = 0;
		quiet_send = 1'b0;
		n_entries  = 0;
		sum_total  = '0;

		// empty table, zero weight, extreme weights and fractions, clear
		add_row(MODE_SAMPLE, 32'h0,        32'h0,        1, make_res(0, STATUS_EMPTY, 0));
		add_row(MODE_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, make_res(0, STATUS_EMPTY, 0));
		add_row(MODE_APPEND, 32'h0,        32'h0,        1, make_res(0, STATUS_OK, 0));
		add_row(MODE_SAMPLE, 32'h0,        32'h7B,       1, make_res(0, STATUS_EMPTY, 0));
		add_row(MODE_APPEND, 32'hFFFFFFFF, 32'h0,        1,
			make_res(1, STATUS_OK, 40'hFFFFFFFF));
		add_row(MODE_SAMPLE, 32'h0,        32'h0,        1,
			make_res(1, STATUS_OK, 40'hFFFFFFFF));
		add_row(MODE_SAMPLE, 32'h0,        32'hFFFFFFFF, 1,
			make_res(1, STATUS_OK, 40'hFFFFFFFF));
		add_row(MODE_APPEND, 32'h1,        32'h0,        1,
			make_res(2, STATUS_OK, 40'h100000000));
		add_row(MODE_SAMPLE, 32'h0,        32'hFFFFFFFF, 0, '0);
		add_row(MODE_APPEND, 32'h0,        32'h0,        1,
			make_res(3, STATUS_OK, 40'h100000000));
		add_row(MODE_APPEND, 32'h5,        32'h0,        0, '0);
		add_row(MODE_SAMPLE, 32'h0,        32'h80000000, 0, '0);
		add_row(MODE_REMOVE, 32'h0,        32'hFFFFFFFF, 0, '0);
		add_row(MODE_REMOVE, 32'h0,        32'h0,        0, '0);
		add_row(MODE_SAMPLE, 32'h0,        32'h0,        0, '0);
		add_row(MODE_REMOVE, 32'h0,        32'h0,        0, '0);
		add_row(MODE_SAMPLE, 32'h0,        32'h12345678, 1, make_res(0, STATUS_EMPTY, 0));
		add_row(MODE_REMOVE, 32'h0,        32'h0,        1, make_res(0, STATUS_EMPTY, 0));
		add_row(MODE_APPEND, 32'hAAAAAAAA, 32'h0,        0, '0);
		add_row(MODE_APPEND, 32'h55555555, 32'h0,        0, '0);
		add_row(MODE_SAMPLE, 32'h0,        32'hAAAAAAAA, 0, '0);
		add_row(MODE_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF, 1, make_res(0, STATUS_OK, 0));
		add_row(MODE_SAMPLE, 32'h0,        32'h55555555, 1, make_res(0, STATUS_EMPTY, 0));
		add_row(MODE_APPEND, 32'h7,        32'h0,        1, make_res(0, STATUS_OK, 40'h7));
		add_row(MODE_CLEAR,  32'h0,        32'h0,        1, make_res(0, STATUS_OK, 0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i])
			push_item(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

		// random rounds, with occasional raw noise
		while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 10))
					push_item(make_cmd(2'($urandom_range(0, 3)), $urandom, $urandom),
						1'b0, '0);
			end else begin
				run_draw_round();
			end
		end
		@(negedge clk);
		cmd_valid <= 1'b0;

		// drain, then wait for stray results
		while (pick_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0 && pick_queue.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
